FILE: hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the sorted key table: request and entry
// layouts, operation and status codes, back end state encoding.
// ----------------------------------------------------------------------------
package skt_pkg;

  // default table capacity
  localparam int TABLE_DEPTH_DEF = 64;

  // entries in the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // fixed field widths
  localparam int KEY_W    = 48;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 7;

  // request operation
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_HIT       = 3'd3,
    ST_MISS      = 3'd4
  } status_t;

  // classified request as held in the queue
  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  // one stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SEARCH,
    BS_COMPARE,
    BS_PROBE,
    BS_SHIFT,
    BS_WRITE,
    BS_FINISH
  } back_state_t;

endpackage

FILE: hdl/skt_front.sv
// ----------------------------------------------------------------------------
// skt_front
// Input stage: takes requests from the stream, decodes the request kind
// into an operation code and holds the request until the queue has room.
// ----------------------------------------------------------------------------
module skt_front
  import skt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // key_addr[47:0], handle_in[79:48]
  input  logic [0:0]  s_tuser,   // req_type[0]
  output logic        push_valid,
  input  logic        push_ready,
  output req_t        push_data
);

  logic hold_valid;
  req_t hold;
  req_t decoded;

  // decode request kind
  always_comb begin
    decoded.key    = s_tdata[KEY_W-1:0];
    decoded.handle = s_tdata[KEY_W+HANDLE_W-1:KEY_W];
    unique case (s_tuser[0])
      1'b0:    decoded.op = OP_INSERT;
      1'b1:    decoded.op = OP_LOOKUP;
      default: decoded.op = OP_INSERT;
    endcase
  end

  // free when empty or when the held request moves on this cycle
  assign s_tready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_data  = hold;

  // hold register control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  // hold register payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold <= decoded;
    end
  end

endmodule

FILE: hdl/skt_queue.sv
// ----------------------------------------------------------------------------
// skt_queue
// Short request queue between front and back end so that each side stalls
// on its own.
// ----------------------------------------------------------------------------
module skt_queue
  import skt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output req_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hdl/skt_back.sv
// ----------------------------------------------------------------------------
// skt_back
// Back end: binary search over the sorted entry memory, tail shift and
// write on insert, result register toward the output stream.
// ----------------------------------------------------------------------------
module skt_back
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_pop,
  input  req_t                                 req_data,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output status_t                              res_status,
  output logic [HANDLE_W-1:0]                  res_handle,
  output logic [SLOT_W-1:0]                    res_slot,
  output logic [$clog2(TABLE_DEPTH + 1)-1:0]   entry_count
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // entry memory, no reset: only entries below the count are ever used
  entry_t        mem [TABLE_DEPTH];
  entry_t        rd_q;
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;

  // sequencer registers
  back_state_t   state, state_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [IW-1:0] mid, mid_next;
  logic [IW-1:0] j, j_next;
  logic [IW-1:0] wa, wa_next;
  logic          pend, pend_next;
  logic          rd_left, rd_left_next;
  logic [CW-1:0] cnt, cnt_next;
  req_t          item, item_next;
  status_t       st, st_next;
  logic [HANDLE_W-1:0] hout, hout_next;

  // output register
  logic                out_valid, out_valid_next;
  status_t             out_status, out_status_next;
  logic [HANDLE_W-1:0] out_handle, out_handle_next;
  logic [SLOT_W-1:0]   out_slot, out_slot_next;

  logic [CW:0]   mid_sum;
  logic [IW-1:0] mid_calc;

  assign mid_sum     = {1'b0, lo} + {1'b0, hi};
  assign mid_calc    = mid_sum[IW:1];
  assign res_valid   = out_valid;
  assign res_status  = out_status;
  assign res_handle  = out_handle;
  assign res_slot    = out_slot;
  assign entry_count = cnt;

  // next state and datapath control
  always_comb begin
    logic found;
    found           = 1'b0;
    state_next      = state;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    j_next          = j;
    wa_next         = wa;
    pend_next       = pend;
    rd_left_next    = rd_left;
    cnt_next        = cnt;
    item_next       = item;
    st_next         = st;
    hout_next       = hout;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_handle_next = out_handle;
    out_slot_next   = out_slot;
    req_pop         = 1'b0;
    raddr           = mid;
    we              = 1'b0;
    waddr           = wa;
    wdata           = rd_q;

    // result taken downstream
    if (out_valid && res_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      BS_IDLE: begin
        if (req_valid) begin
          req_pop    = 1'b1;
          item_next  = req_data;
          lo_next    = '0;
          hi_next    = cnt;
          state_next = BS_SEARCH;
        end
      end

      // one halving step: read the middle entry, or the entry at the lower bound once the range is empty
      BS_SEARCH: begin
        if (lo < hi) begin
          mid_next   = mid_calc;
          raddr      = mid_calc;
          state_next = BS_COMPARE;
        end else begin
          raddr      = lo[IW-1:0];
          state_next = BS_PROBE;
        end
      end

      BS_COMPARE: begin
        if (rd_q.key < item.key) begin
          lo_next = CW'(mid) + CW'(1);
        end else begin
          hi_next = CW'(mid);
        end
        state_next = BS_SEARCH;
      end

      // entry at the lower bound decides the outcome
      BS_PROBE: begin
        found     = (lo < cnt) && (rd_q.key == item.key);
        hout_next = found ? rd_q.handle : '0;
        if (item.op == OP_LOOKUP) begin
          st_next    = found ? ST_HIT : ST_MISS;
          state_next = BS_FINISH;
        end else if (found) begin
          st_next    = ST_DUPLICATE;
          state_next = BS_FINISH;
        end else if (cnt == CW'(TABLE_DEPTH)) begin
          st_next    = ST_FULL;
          state_next = BS_FINISH;
        end else begin
          st_next = ST_INSERTED;
          if (cnt != lo) begin
            j_next       = IW'(cnt - CW'(1));
            rd_left_next = 1'b1;
            pend_next    = 1'b0;
            state_next   = BS_SHIFT;
          end else begin
            state_next = BS_WRITE;
          end
        end
      end

      // streaming tail shift: read entry j, write it one place up next cycle
      BS_SHIFT: begin
        if (pend) begin
          we    = 1'b1;
          waddr = wa;
          wdata = rd_q;
        end
        if (rd_left) begin
          raddr        = j;
          pend_next    = 1'b1;
          wa_next      = j + IW'(1);
          rd_left_next = (CW'(j) != lo);
          j_next       = j - IW'(1);
        end else begin
          pend_next  = 1'b0;
          state_next = BS_WRITE;
        end
      end

      BS_WRITE: begin
        we           = 1'b1;
        waddr        = lo[IW-1:0];
        wdata.key    = item.key;
        wdata.handle = item.handle;
        cnt_next     = cnt + CW'(1);
        state_next   = BS_FINISH;
      end

      // hand the result to the output register once it is free
      BS_FINISH: begin
        if (!out_valid || res_ready) begin
          out_valid_next  = 1'b1;
          out_status_next = st;
          out_handle_next = hout;
          out_slot_next   = SLOT_W'(lo);
          state_next      = BS_IDLE;
        end
      end

      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      rd_left   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pend      <= pend_next;
      rd_left   <= rd_left_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    j          <= j_next;
    wa         <= wa_next;
    item       <= item_next;
    st         <= st_next;
    hout       <= hout_next;
    out_status <= out_status_next;
    out_handle <= out_handle_next;
    out_slot   <= out_slot_next;
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

endmodule

FILE: hdl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of (start key, handle) pairs kept in ascending key order, with
// insert and exact-match lookup by binary search.
//
//   channel  dir  tvalid/tready       payload
//   s_*      in   request             tdata: key_addr, handle_in; tuser: req_type
//   m_*      out  result              tdata: handle_out, slot_index; tuser: status
//
// A lookup runs a binary search over the n stored entries, stepping through
// the search and compare states, then probes the entry at the lower bound;
// an insert of a new key adds a shift of each entry above the insert position
// and a write. The search steps and the tail shift share the single read and
// write port of the entry memory. Reset empties the table; the memory itself
// is not cleared. The front register and queue keep taking requests while the
// back end works and while a result waits in the output register, until full.
// ----------------------------------------------------------------------------
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // key_addr[47:0], handle_in[79:48]
  input  logic [0:0]  s_tuser,   // req_type[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // handle_out[31:0], slot_index[38:32], zero[39]
  output logic [2:0]  m_tuser    // status[2:0]
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                push_valid;
  logic                push_ready;
  req_t                push_data;
  logic                q_valid;
  logic                q_pop;
  req_t                q_data;
  status_t             res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [SLOT_W-1:0]   res_slot;
  logic [CW-1:0]       entry_count;

  // request intake and decode
  skt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  skt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  // search and update engine
  skt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (q_valid),
    .req_pop     (q_pop),
    .req_data    (q_data),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res_status  (res_status),
    .res_handle  (res_handle),
    .res_slot    (res_slot),
    .entry_count (entry_count)
  );

  // result packing
  assign m_tdata = {1'b0, res_slot, res_handle};
  assign m_tuser = res_status;

  // the table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count above capacity");

  // the count only grows, and by one at a time
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (entry_count == $past(entry_count)) ||
             (entry_count == $past(entry_count) + CW'(1)))
    else $error("entry count changed by other than one");

  // results without a matched entry carry no handle
  a_no_handle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == ST_INSERTED) || (m_tuser == ST_FULL) ||
                 (m_tuser == ST_MISS)) |-> (m_tdata[31:0] == '0))
    else $error("handle reported without a matching entry");

endmodule
